// ----- sv/esc_pkg.sv -----
`timescale 1ns / 1ps

package esc_pkg;

  // width of the shared compare-subtract unit
  localparam int unsigned SubW = 18;

  localparam logic [11:0] BaseYearReset = 12'd2000;

  localparam logic [SubW-1:0] SecsPerDay  = 18'd86400;
  localparam logic [SubW-1:0] SecsPerHour = 18'd3600;
  localparam logic [SubW-1:0] SecsPerMin  = 18'd60;
  localparam logic [SubW-1:0] DaysLeap    = 18'd366;
  localparam logic [SubW-1:0] DaysCommon  = 18'd365;

  // reciprocal constants for the weekday and leap-cycle setup
  localparam logic [12:0] WdayOffset = 13'd399;
  localparam logic [25:0] Recip100   = 26'd5243;   // 2^19 / 100, rounded up
  localparam logic [26:0] Recip7     = 27'd9363;   // 2^16 / 7, rounded up
  localparam logic [12:0] LeapCycle  = 13'd400;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP1,
    S_PREP2,
    S_PREP3,
    S_PREP4,
    S_DIV,
    S_HOUR,
    S_MIN,
    S_YEAR,
    S_MONTH
  } state_t;

  typedef struct packed {
    logic            ge;
    logic [SubW-1:0] diff;
  } sub_res_t;

  // leap test from the year modulo 400
  function automatic logic is_leap(input logic [8:0] y400);
    logic by4;
    logic cent;
    by4  = (y400[1:0] == 2'd0);
    cent = (y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300);
    return (by4 && !cent) || (y400 == 9'd0);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m) inside
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // x mod 7 for x below 64, quotient by reciprocal 37/256
  function automatic logic [2:0] mod7_small(input logic [5:0] x);
    logic [11:0] prod;
    logic [5:0]  q;
    logic [5:0]  r;
    prod = {6'd0, x} * 12'd37;
    q    = {2'd0, prod[11:8]};
    r    = x - ((q << 3) - q);
    return r[2:0];
  endfunction

endpackage

// ----- sv/esc_cmpsub.sv -----
`timescale 1ns / 1ps

module esc_cmpsub import esc_pkg::*; (
  input  logic [SubW-1:0] a,
  input  logic [SubW-1:0] b,
  output sub_res_t        res
);

  logic [SubW:0] wide;

  // borrow out clear means a >= b
  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.diff = wide[SubW-1:0];
  assign res.ge   = ~wide[SubW];

endmodule

// ----- sv/epoch_seconds_to_calendar.sv -----
`timescale 1ns / 1ps

// epoch seconds to gregorian calendar converter
// a transaction is taken when start is high and busy is low; seconds counts
// from midnight of 1 january of base_year, which is written on the cfg
// channel (cfg_ready is high only while the block is idle and start is low,
// so a base year write never lands on the edge that takes a transaction;
// reset value 2000). the block answers each transaction with exactly one
// result, shown on the result ports for the one cycle in which done is high;
// there is no back-pressure, so the receiver must capture it then. the day
// split, hour and minute and the year and month walks run on a single
// 18-bit compare-subtract unit, after a setup of the weekday and leap cycle
// of the base year. the walks take off one whole year or month per cycle;
// each ends once the next year or month no longer fits, the month walk also
// at december. start may be raised again in the done cycle. years past 4095
// wrap in the year field; leap rules see the full year

module epoch_seconds_to_calendar import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [31:0] seconds,
  // base year write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data,
  // result, valid for the single cycle of done
  output logic        done,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  month_day,
  output logic [8:0]  year_day,
  output logic [2:0]  week_day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  state_t state, state_next;
  logic   done_next;

  logic [11:0] base_year;

  // division datapath: acc is the partial remainder, sh holds the dividend
  // low bits on the way in and the day count afterwards
  logic [SubW-1:0] acc;
  logic [15:0]     sh;
  logic [3:0]      cnt;

  // weekday and leap-cycle setup
  logic [5:0]  p100;
  logic [12:0] wsum;
  logic [9:0]  q7;
  logic [2:0]  wd;
  logic [8:0]  y400;

  logic [12:0] yr;
  logic [4:0]  hr;
  logic [5:0]  mn;
  logic [3:0]  mon;
  logic [8:0]  yday;

  // setup arithmetic
  logic [12:0] p;
  logic [25:0] p_prod;
  logic [26:0] w_prod;
  logic [12:0] pm400;
  logic [12:0] wrem;

  logic            leap;
  logic [4:0]      mlen;
  logic [SubW-1:0] sub_a;
  logic [SubW-1:0] sub_b;
  sub_res_t        sub_res;

  assign busy      = (state != S_IDLE);
  // a pending start wins over a base year write
  assign cfg_ready = ~busy & ~start;

  assign p      = {1'b0, base_year} + WdayOffset;
  assign p_prod = {13'd0, p} * Recip100;
  assign w_prod = {14'd0, wsum} * Recip7;
  // p mod 400, using p/400 = (p/100)/4
  assign pm400  = p - ({9'd0, p100[5:2]} * LeapCycle);
  assign wrem   = wsum - (({3'd0, q7} << 3) - {3'd0, q7});

  assign leap = is_leap(y400);
  assign mlen = month_len(mon, leap);

  // operand select for the shared unit
  always_comb begin
    unique case (state)
      S_DIV: begin
        sub_a = {acc[SubW-2:0], sh[15]};
        sub_b = SecsPerDay;
      end
      S_HOUR: begin
        sub_a = acc;
        sub_b = SecsPerHour << cnt[2:0];
      end
      S_MIN: begin
        sub_a = acc;
        sub_b = SecsPerMin << cnt[2:0];
      end
      S_YEAR: begin
        sub_a = {2'd0, sh};
        sub_b = leap ? DaysLeap : DaysCommon;
      end
      S_MONTH: begin
        sub_a = {2'd0, sh};
        sub_b = {13'd0, mlen};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  esc_cmpsub u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .res (sub_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    unique case (state)
      S_IDLE:  if (start) state_next = S_PREP1;
      S_PREP1: state_next = S_PREP2;
      S_PREP2: state_next = S_PREP3;
      S_PREP3: state_next = S_PREP4;
      S_PREP4: state_next = S_DIV;
      S_DIV:   if (cnt == 4'd0) state_next = S_HOUR;
      S_HOUR:  if (cnt == 4'd0) state_next = S_MIN;
      S_MIN:   if (cnt == 4'd0) state_next = S_YEAR;
      S_YEAR:  if (!sub_res.ge) state_next = S_MONTH;
      S_MONTH: begin
        if (mon == 4'd12 || !sub_res.ge) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // base year register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_year <= BaseYearReset;
    end else if (cfg_valid && cfg_ready) begin
      base_year <= cfg_data;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        acc <= {2'd0, seconds[31:16]};
        sh  <= seconds[15:0];
        cnt <= 4'd15;
        yr  <= {1'b0, base_year};
      end
      S_PREP1: begin
        p100 <= p_prod[24:19];
      end
      S_PREP2: begin
        // jan 1 weekday sum over (year - 1), and year mod 400
        wsum <= p + (p >> 2) - {7'd0, p100} + {9'd0, p100[5:2]} + 13'd1;
        y400 <= (pm400[8:0] == 9'd399) ? 9'd0 : pm400[8:0] + 9'd1;
      end
      S_PREP3: begin
        q7 <= w_prod[25:16];
      end
      S_PREP4: begin
        wd <= wrem[2:0];
      end
      S_DIV: begin
        acc <= sub_res.ge ? sub_res.diff : sub_a;
        sh  <= {sh[14:0], sub_res.ge};
        cnt <= (cnt == 4'd0) ? 4'd4 : cnt - 4'd1;
      end
      S_HOUR: begin
        if (sub_res.ge) acc <= sub_res.diff;
        hr  <= {hr[3:0], sub_res.ge};
        cnt <= (cnt == 4'd0) ? 4'd5 : cnt - 4'd1;
      end
      S_MIN: begin
        if (sub_res.ge) acc <= sub_res.diff;
        mn  <= {mn[4:0], sub_res.ge};
        cnt <= cnt - 4'd1;
      end
      S_YEAR: begin
        if (sub_res.ge) begin
          sh   <= sub_res.diff[15:0];
          yr   <= yr + 13'd1;
          y400 <= (y400 == 9'd399) ? 9'd0 : y400 + 9'd1;
          wd   <= mod7_small({3'd0, wd} + (leap ? 6'd2 : 6'd1));
        end else begin
          yday <= sh[8:0] + 9'd1;
          mon  <= 4'd1;
        end
      end
      S_MONTH: begin
        if (mon != 4'd12 && sub_res.ge) begin
          sh  <= sub_res.diff[15:0];
          mon <= mon + 4'd1;
          wd  <= mod7_small({3'd0, wd} + {1'b0, mlen});
        end else begin
          year      <= yr[11:0];
          month     <= mon;
          month_day <= sh[4:0] + 5'd1;
          year_day  <= yday;
          week_day  <= mod7_small({3'd0, wd} + sh[5:0]);
          hour      <= hr;
          minute    <= mn;
          second    <= acc[5:0];
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // checks

  a_done_from_month: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_MONTH)
    else $error("result strobe without a finished month walk");

  a_busy_needs_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("sequencer left idle without a command");

  a_wd_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_YEAR || state == S_MONTH) |-> wd < 3'd7)
    else $error("running weekday out of range");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MONTH |-> (mon >= 4'd1 && mon <= 4'd12))
    else $error("month counter out of range");

  a_cycle_range: assert property (@(posedge clk) disable iff (rst)
    state == S_YEAR |-> y400 < 9'd400)
    else $error("leap-cycle position out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hour < 5'd24 && minute < 6'd60 && second < 6'd60))
    else $error("time of day out of range");

endmodule

// ----- bench/epoch_seconds_to_calendar_test.sv -----
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_test;
  import esc_pkg::*;

  // generous bound on the whole run
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SecsInDay  = 86400;
  // last whole day whose final second still fits in 32 bits
  localparam int unsigned LastFullDay = 49709;
  localparam int unsigned ItemsPerPhase = 68;
  localparam int unsigned MaxReports = 30;

  // one calendar result, fields at the port widths
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  month_day;
    logic [8:0]  year_day;
    logic [2:0]  week_day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_t;

  // holds the dates still owed by the block and checks each one that arrives
  class calendar_board;
    date_t       owed_dates[$];
    logic [11:0] base_year;
    int unsigned matched;
    int unsigned errors;

    function new();
      base_year = BaseYearReset;
      matched   = 0;
      errors    = 0;
    endfunction

    function bit leap_year(int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function int unsigned days_in_month(int unsigned y, int unsigned m);
      case (m)
        2:           return leap_year(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    // whole days, then whole years, then whole months
    function date_t to_calendar(logic [31:0] secs, logic [11:0] base);
      date_t       d;
      int unsigned days;
      int unsigned rest;
      int unsigned y;
      int unsigned m;
      int unsigned p;
      int unsigned jan1;
      int unsigned yday;
      days = secs / SecsInDay;
      rest = secs % SecsInDay;
      y    = base;
      m    = 1;
      // weekday of 1 january from (year - 1), kept positive by adding 399
      p    = base + 399;
      jan1 = (p + p / 4 - p / 100 + p / 400 + 1) % 7;
      d.week_day = 3'((jan1 + days) % 7);
      while (days >= (leap_year(y) ? 366 : 365)) begin
        days -= leap_year(y) ? 366 : 365;
        y++;
      end
      yday = days + 1;
      while (m < 12 && days >= days_in_month(y, m)) begin
        days -= days_in_month(y, m);
        m++;
      end
      d.year      = 12'(y);
      d.month     = 4'(m);
      d.month_day = 5'(days + 1);
      d.year_day  = 9'(yday);
      d.hour      = 5'(rest / 3600);
      d.minute    = 6'(rest / 60 % 60);
      d.second    = 6'(rest % 60);
      return d;
    endfunction

    function void note_seconds(logic [31:0] secs);
      owed_dates.push_back(to_calendar(secs, base_year));
    endfunction

    function void flag(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_date(date_t got);
      date_t want;
      int unsigned errs_before;
      if (owed_dates.size() == 0) begin
        flag("unexpected result, year", 0, got.year);
        return;
      end
      want = owed_dates.pop_front();
      errs_before = errors;
      if (got.year != want.year)           flag("year", want.year, got.year);
      if (got.month != want.month)         flag("month", want.month, got.month);
      if (got.month_day != want.month_day) flag("month_day", want.month_day, got.month_day);
      if (got.year_day != want.year_day)   flag("year_day", want.year_day, got.year_day);
      if (got.week_day != want.week_day)   flag("week_day", want.week_day, got.week_day);
      if (got.hour != want.hour)           flag("hour", want.hour, got.hour);
      if (got.minute != want.minute)       flag("minute", want.minute, got.minute);
      if (got.second != want.second)       flag("second", want.second, got.second);
      if (errors == errs_before) matched++;
    endfunction

    function int unsigned pending();
      return owed_dates.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] seconds = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_data = '0;
  logic        done;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  month_day;
  logic [8:0]  year_day;
  logic [2:0]  week_day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  calendar_board board = new();
  int unsigned   cycles = 0;
  int unsigned   conversions = 0;
  int unsigned   base_writes = 0;

  epoch_seconds_to_calendar dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .seconds   (seconds),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .year      (year),
    .month     (month),
    .month_day (month_day),
    .year_day  (year_day),
    .week_day  (week_day),
    .hour      (hour),
    .minute    (minute),
    .second    (second)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL epoch_seconds_to_calendar");
      $finish;
    end
  end

  // the result shows for one cycle only, so every done is captured here
  always @(posedge clk) begin
    if (!rst && done)
      board.check_date({year, month, month_day, year_day, week_day, hour, minute, second});
  end

  // random seconds, weighted toward day edges, the first years and the ends of the range
  function automatic logic [31:0] pick_seconds();
    int unsigned sel;
    int unsigned d;
    sel = $urandom_range(0, 99);
    d   = $urandom_range(0, LastFullDay);
    if (sel < 35)
      return $urandom;
    else if (sel < 55)
      return $urandom_range(0, 800 * SecsInDay - 1);
    else if (sel < 80)
      return d * SecsInDay + ($urandom_range(0, 1) ? SecsInDay - 1 : 0);
    else if (sel < 90)
      return $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 400 * SecsInDay)
                                  : $urandom_range(0, 3600);
    else
      return d * SecsInDay + $urandom_range(0, SecsInDay - 1);
  endfunction

  // one conversion transaction, optionally after a burst of idle cycles
  task automatic convert(logic [31:0] secs, bit idle_ok);
    int unsigned gap;
    gap = 0;
    if (idle_ok && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      @(negedge clk);
      start   <= 1'b0;
      seconds <= $urandom;
      // sometimes let the block finish first so the gap lands on an idle block
      if ($urandom_range(0, 1)) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start   <= 1'b1;
    seconds <= secs;
    do @(posedge clk); while (busy);
    board.note_seconds(secs);
    conversions++;
  endtask

  // wait for every owed date, start is already low here
  task automatic drain();
    while (board.pending() != 0) @(posedge clk);
  endtask

  // base year write, only called with the block idle
  task automatic write_base(logic [11:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.base_year = value;
    base_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= $urandom;
  endtask

  task automatic end_stream();
    @(negedge clk);
    start   <= 1'b0;
    seconds <= $urandom;
  endtask

  initial begin
    logic [31:0] edge_cases[$];
    logic [11:0] bases[$];
    edge_cases = '{
      32'd0, 32'd59, 32'd3599, 32'd86399, 32'd86400,
      32'd2678399,                 // last second of january
      32'd5097600,                 // 29 february of a year divisible by 400
      32'd31536000,                // 31 december of a leap year, day 366
      32'd31622400,                // first second of the following year
      32'd3160857599,              // 28 february of a century year that is not leap
      32'd3160857600,              // 1 march right after it
      32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h5555_5555, 32'hAAAA_AAAA
    };
    // extremes, base year zero, a base year that pushes the year past 12 bits
    bases = '{12'd1900, 12'd2099, 12'd0, 12'd4095, 12'd1970,
              12'($urandom_range(0, 4095)), 12'($urandom_range(1900, 2099)), 12'd2000};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset base year first, directed cases then random
    foreach (edge_cases[i]) convert(edge_cases[i], 1'b1);
    repeat (ItemsPerPhase - 8) convert(pick_seconds(), 1'b1);
    end_stream();

    foreach (bases[i]) begin
      drain();
      write_base(bases[i]);
      // no idling in the final phase
      repeat (ItemsPerPhase) convert(pick_seconds(), i != bases.size() - 1);
      end_stream();
    end

    drain();
    repeat (250) @(posedge clk);

    $display("covered %0d conversions over %0d base year writes plus the reset value",
             conversions, base_writes);
    $display("%0d results matched, %0d field errors", board.matched, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS epoch_seconds_to_calendar");
    end else begin
      $display("FAIL epoch_seconds_to_calendar");
    end
    $finish;
  end

endmodule
